// ----- rtl/binomial_european_option_pricer_defines.svh -----
// Assertion macros for the binomial option pricer.
`ifndef BINOMIAL_EUROPEAN_OPTION_PRICER_DEFINES_SVH
`define BINOMIAL_EUROPEAN_OPTION_PRICER_DEFINES_SVH

`ifndef SYNTHESIS
`define BOP_ASSERT_IMPL(lbl, ante, cons) \
lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
    else $error("bop assertion failed");
`define BOP_ASSERT_NEXT(lbl, ante, cons) \
lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
    else $error("bop assertion failed");
`else
`define BOP_ASSERT_IMPL(lbl, ante, cons)
`define BOP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/bop_pkg.sv -----
`timescale 1ns / 1ps
package bop_pkg;
    localparam int MAX_STEPS = 256;
    localparam int WDEPTH    = MAX_STEPS + 1;
    localparam int WADDR_W   = $clog2(WDEPTH);
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_UP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROB  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DISC  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS = 3'd4;

    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
    localparam logic [59:0] ONE_Q28 = 60'h000_0000_1000_0000;

    typedef enum logic [18:0] {
        S_IDLE   = 19'b000_0000_0000_0000_0001,
        S_WINIT  = 19'b000_0000_0000_0000_0010,
        S_WRD    = 19'b000_0000_0000_0000_0100,
        S_WM1    = 19'b000_0000_0000_0000_1000,
        S_WM2    = 19'b000_0000_0000_0001_0000,
        S_WWR    = 19'b000_0000_0000_0010_0000,
        S_NSTART = 19'b000_0000_0000_0100_0000,
        S_FSEL   = 19'b000_0000_0000_1000_0000,
        S_FM1    = 19'b000_0000_0001_0000_0000,
        S_FM2    = 19'b000_0000_0010_0000_0000,
        S_FCB    = 19'b000_0000_0100_0000_0000,
        S_PAY    = 19'b000_0000_1000_0000_0000,
        S_TM1    = 19'b000_0001_0000_0000_0000,
        S_TM2    = 19'b000_0010_0000_0000_0000,
        S_TACC   = 19'b000_0100_0000_0000_0000,
        S_D1     = 19'b000_1000_0000_0000_0000,
        S_D2     = 19'b001_0000_0000_0000_0000,
        S_D3     = 19'b010_0000_0000_0000_0000,
        S_OUT    = 19'b100_0000_0000_0000_0000
    } t_state;
endpackage

// ----- rtl/bop_if.sv -----
`timescale 1ns / 1ps
interface bop_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] spot_price;
    logic [31:0] strike_price;
    modport source (output valid, spot_price, strike_price, input ready);
    modport sink (input valid, spot_price, strike_price, output ready);
endinterface

interface bop_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] call_price;
    logic [31:0] put_price;
    logic        saturated;
    modport source (output valid, call_price, put_price, saturated, input ready);
    modport sink (input valid, call_price, put_price, saturated, output ready);
endinterface

interface bop_cfg_if import bop_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/bop_mul.sv -----
`timescale 1ns / 1ps
module bop_mul import bop_pkg::*; (
    input  logic        i_clk,
    input  logic [32:0] i_a,
    input  logic [32:0] i_b,
    output logic [65:0] o_prod
);
    logic [65:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;
endmodule

// ----- rtl/bop_wram.sv -----
`timescale 1ns / 1ps
module bop_wram import bop_pkg::*; (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [WADDR_W-1:0] i_waddr,
    input  logic [32:0]        i_wdata,
    input  logic               i_re,
    input  logic [WADDR_W-1:0] i_raddr,
    output logic [32:0]        o_rdata
);
    logic [32:0] r_mem [WDEPTH];
    logic [32:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/binomial_european_option_pricer.sv -----
`timescale 1ns / 1ps
// Channel  Dir  Payload                               Accepted when
// i_in     in   spot_price, strike_price              valid && ready
// o_out    out  call_price, put_price, saturated      valid && ready
// i_cfg    in   index (0..4), data                    valid && ready (always ready)
// One request: seed the weight row, build the weights row by row (read, two multiplies,
// write per entry), then per terminal node form the price from the up/down factors and
// spot, weight both payoffs, then discount and load the output, all on the single shared
// 33x33 multiplier. A clipped node factor skips that node's remaining multiplies.
// Synchronous active-low reset returns the sequencer to idle and restores config registers.
// A stalled result holds in the output register; the next result waits in S_OUT until taken.
`include "binomial_european_option_pricer_defines.svh"
module binomial_european_option_pricer import bop_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    bop_in_if.sink    i_in,
    bop_out_if.source o_out,
    bop_cfg_if.sink   i_cfg
);
    t_state r_state, n_state;

    logic [31:0] r_up_f, r_disc, r_prob;
    logic [28:0] r_dn_f;
    logic [8:0]  r_steps;

    logic [31:0] r_spot, n_spot, r_strike, n_strike;
    logic [WADDR_W-1:0] r_n, n_n, r_st, n_st, r_j, n_j;
    logic [WADDR_W-1:0] r_pr, n_pr, r_up, n_up, r_dn, n_dn;
    logic        r_half, n_half, r_isp, n_isp, r_clip, n_clip, r_any, n_any;
    logic [32:0] r_cur, n_cur, r_w, n_w;
    logic [63:0] r_acc_w, n_acc_w;
    logic [59:0] r_f, n_f, r_hi, n_hi;
    logic [31:0] r_x, n_x, r_price, n_price, r_cpay, n_cpay, r_ppay, n_ppay;
    logic [41:0] r_sc, n_sc, r_sp, n_sp;
    logic [31:0] r_call, n_call;

    logic        r_ovalid, n_ovalid;
    logic [31:0] r_ocall, n_ocall, r_oput, n_oput;
    logic        r_osat, n_osat;

    logic [32:0] mul_a, mul_b;
    logic [65:0] prod;
    logic               we, re;
    logic [WADDR_W-1:0] waddr, raddr;
    logic [32:0]        wdata, rdata;

    bop_mul u_mul (.i_clk(i_clk), .i_a(mul_a), .i_b(mul_b), .o_prod(prod));

    bop_wram u_wram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_re(re), .i_raddr(raddr), .o_rdata(rdata)
    );

    assign i_cfg.ready     = 1'b1;
    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_ovalid;
    assign o_out.call_price = r_ocall;
    assign o_out.put_price = r_oput;
    assign o_out.saturated = r_osat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_f  <= 32'h1000_0000;
            r_dn_f  <= 29'h1000_0000;
            r_prob  <= 32'h8000_0000;
            r_disc  <= 32'hFFFF_FFFF;
            r_steps <= 9'd1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_UP:    r_up_f  <= i_cfg.data;
                REG_DOWN:  r_dn_f  <= i_cfg.data[28:0];
                REG_PROB:  r_prob  <= i_cfg.data;
                REG_DISC:  r_disc  <= i_cfg.data;
                REG_STEPS: r_steps <= i_cfg.data[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [32:0] q;
        logic [32:0] y;
        logic [WADDR_W-1:0] ups;
        logic [WADDR_W-1:0] pairs;
        logic [64:0] fsum;
        logic [35:0] lo;
        logic        cl;
        logic [31:0] pr;
        logic [31:0] sat;

        n_state = r_state;
        n_spot = r_spot; n_strike = r_strike; n_n = r_n; n_st = r_st; n_j = r_j;
        n_pr = r_pr; n_up = r_up; n_dn = r_dn; n_half = r_half; n_isp = r_isp;
        n_clip = r_clip; n_any = r_any; n_cur = r_cur; n_acc_w = r_acc_w;
        n_w = r_w; n_f = r_f; n_hi = r_hi; n_x = r_x; n_price = r_price;
        n_cpay = r_cpay; n_ppay = r_ppay; n_sc = r_sc; n_sp = r_sp; n_call = r_call;
        n_ovalid = r_ovalid; n_ocall = r_ocall; n_oput = r_oput; n_osat = r_osat;
        mul_a = '0; mul_b = '0;
        we = 1'b0; re = 1'b0; waddr = r_j; raddr = r_j; wdata = '0;
        q = ONE_Q32 - {1'b0, r_prob};
        y = (r_j == '0) ? 33'd0 : rdata;
        ups = r_n - r_j;
        pairs = (ups < r_j) ? ups : r_j;
        lo = prod[63:28];
        fsum = {1'b0, r_hi, 4'b0} + {29'd0, lo};
        cl = 1'b0;
        pr = r_clip ? 32'hFFFF_FFFF : r_price;
        sat = 32'd0;

        if (o_out.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_spot = i_in.spot_price;
                    n_strike = i_in.strike_price;
                    if (r_steps == 9'd0) begin
                        n_n = WADDR_W'(1);
                    end else if (int'(r_steps) > MAX_STEPS) begin
                        n_n = WADDR_W'(MAX_STEPS);
                    end else begin
                        n_n = WADDR_W'(r_steps);
                    end
                    n_state = S_WINIT;
                end
            end
            S_WINIT: begin
                we = 1'b1; waddr = '0; wdata = ONE_Q32;
                n_st = WADDR_W'(1); n_j = WADDR_W'(1); n_cur = '0;
                n_sc = '0; n_sp = '0; n_any = 1'b0;
                n_state = S_WRD;
            end
            S_WRD: begin
                re = (r_j != '0); raddr = r_j - 1'b1;
                n_state = S_WM1;
            end
            S_WM1: begin
                mul_a = {1'b0, r_prob}; mul_b = r_cur;
                n_state = S_WM2;
            end
            S_WM2: begin
                n_acc_w = prod[63:0];
                mul_a = q; mul_b = y;
                n_state = S_WWR;
            end
            S_WWR: begin
                fsum = {1'b0, r_acc_w} + prod[64:0];
                we = 1'b1; waddr = r_j; wdata = fsum[64:32];
                n_cur = y;
                if (r_j == '0) begin
                    if (r_st == r_n) begin
                        n_j = '0;
                        n_state = S_NSTART;
                    end else begin
                        n_st = r_st + 1'b1;
                        n_j = r_st + 1'b1;
                        n_cur = '0;
                        n_state = S_WRD;
                    end
                end else begin
                    n_j = r_j - 1'b1;
                    n_state = S_WRD;
                end
            end
            S_NSTART: begin
                re = 1'b1; raddr = r_j;
                n_pr = pairs; n_up = ups - pairs; n_dn = r_j - pairs;
                n_half = 1'b0; n_isp = 1'b0; n_clip = 1'b0; n_f = ONE_Q28;
                n_state = S_FSEL;
            end
            S_FSEL: begin
                n_state = S_FM1;
                if (r_clip) begin
                    n_state = S_PAY;
                end else if (r_pr != '0) begin
                    n_x = r_half ? {3'd0, r_dn_f} : r_up_f;
                    n_half = !r_half;
                    if (r_half) begin
                        n_pr = r_pr - 1'b1;
                    end
                end else if (r_up != '0) begin
                    n_x = r_up_f; n_up = r_up - 1'b1;
                end else if (r_dn != '0) begin
                    n_x = {3'd0, r_dn_f}; n_dn = r_dn - 1'b1;
                end else begin
                    n_x = r_spot; n_isp = 1'b1;
                end
            end
            S_FM1: begin
                mul_a = {5'd0, r_f[59:32]}; mul_b = {1'b0, r_x};
                n_state = S_FM2;
            end
            S_FM2: begin
                n_hi = prod[59:0];
                mul_a = {1'b0, r_f[31:0]}; mul_b = {1'b0, r_x};
                n_state = S_FCB;
            end
            S_FCB: begin
                if (r_isp) begin
                    cl = (r_hi >= 60'h000_0000_1000_0000) || (fsum >= 65'h1_0000_0000);
                end else begin
                    cl = (r_hi >= 60'h100_0000_0000_0000) ||
                         (fsum >= 65'h0_1000_0000_0000_0000);
                end
                if (cl) begin
                    n_clip = 1'b1;
                end
                n_f = fsum[59:0];
                n_price = fsum[31:0];
                n_state = (r_isp || cl) ? S_PAY : S_FSEL;
            end
            S_PAY: begin
                n_w = rdata;
                n_any = r_any | r_clip;
                n_cpay = (pr > r_strike) ? pr - r_strike : 32'd0;
                n_ppay = (r_strike > pr) ? r_strike - pr : 32'd0;
                n_state = S_TM1;
            end
            S_TM1: begin
                mul_a = r_w; mul_b = {1'b0, r_cpay};
                n_state = S_TM2;
            end
            S_TM2: begin
                n_sc = r_sc + {8'd0, prod[65:32]};
                mul_a = r_w; mul_b = {1'b0, r_ppay};
                n_state = S_TACC;
            end
            S_TACC: begin
                n_sp = r_sp + {8'd0, prod[65:32]};
                if (r_j == r_n) begin
                    n_state = S_D1;
                end else begin
                    n_j = r_j + 1'b1;
                    n_state = S_NSTART;
                end
            end
            S_D1: begin
                sat = (r_sc > 42'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : r_sc[31:0];
                mul_a = {1'b0, sat}; mul_b = {1'b0, r_disc};
                n_state = S_D2;
            end
            S_D2: begin
                n_call = prod[63:32];
                sat = (r_sp > 42'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : r_sp[31:0];
                mul_a = {1'b0, sat}; mul_b = {1'b0, r_disc};
                n_state = S_D3;
            end
            S_D3: begin
                n_price = prod[63:32];
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_ocall = r_call;
                    n_oput = r_price;
                    n_osat = r_any;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_spot <= n_spot; r_strike <= n_strike; r_n <= n_n; r_st <= n_st; r_j <= n_j;
        r_pr <= n_pr; r_up <= n_up; r_dn <= n_dn; r_half <= n_half; r_isp <= n_isp;
        r_clip <= n_clip; r_any <= n_any; r_cur <= n_cur; r_acc_w <= n_acc_w;
        r_w <= n_w; r_f <= n_f; r_hi <= n_hi; r_x <= n_x; r_price <= n_price;
        r_cpay <= n_cpay; r_ppay <= n_ppay; r_sc <= n_sc; r_sp <= n_sp; r_call <= n_call;
        r_ocall <= n_ocall; r_oput <= n_oput; r_osat <= n_osat;
    end

    `BOP_ASSERT_NEXT(a_accept_starts, i_in.valid && i_in.ready, r_state == S_WINIT)
    `BOP_ASSERT_IMPL(a_write_in_row, we, r_state == S_WINIT || r_state == S_WWR)
    `BOP_ASSERT_IMPL(a_node_in_range, r_state == S_NSTART, r_j <= r_n)
    `BOP_ASSERT_IMPL(a_out_after_done, !r_ovalid && n_ovalid, r_state == S_OUT)
endmodule
